/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge out of reset.
`define LSCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LSCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lscr_pkg.sv */
// Types, outcode constants and the region function of the line clipper.
`default_nettype none
package lscr_pkg;

  typedef logic signed [23:0] coord_t;
  typedef logic [3:0] code_t;

  localparam code_t CODE_LEFT   = 4'd1;
  localparam code_t CODE_RIGHT  = 4'd2;
  localparam code_t CODE_BOTTOM = 4'd4;
  localparam code_t CODE_TOP    = 4'd8;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = -24'sh800000;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } window_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    code_t  ca;
    code_t  cb;
  } seg_t;

  function automatic code_t region_of(input coord_t x, input coord_t y,
                                      input window_t w);
    code_t c;
    c = '0;
    if (x < w.left) c = c | CODE_LEFT;
    else if (x > w.right) c = c | CODE_RIGHT;
    if (y < w.bottom) c = c | CODE_BOTTOM;
    else if (y > w.top) c = c | CODE_TOP;
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/line_segment_rect_clipper_core.sv */
// Top level of the Cohen-Sutherland segment clipper: window registers and units.
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | in_start_x, in_start_y, in_end_x, in_end_y
//  out     | out_valid / out_ready  | out_accepted, out_clipped_*
//  cfg     | cfg_we                 | cfg_index, cfg_wdata
//
// A segment makes at most MAX_PASSES clip passes, and the serial divider
// computes each edge crossing.
// Reset is synchronous and active low; the window resets to (0,0)-(max,max).
// A two-entry queue takes new segments while the sequencer works, and the
// output register holds a finished transaction while the next one is clipped.
`default_nettype none
`include "assert_macros.svh"
module line_segment_rect_clipper_core #(
  parameter int MAX_PASSES = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [23:0]      cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lscr_pkg::coord_t in_start_x,
  input  wire lscr_pkg::coord_t in_start_y,
  input  wire lscr_pkg::coord_t in_end_x,
  input  wire lscr_pkg::coord_t in_end_y,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_accepted,
  output lscr_pkg::coord_t      out_clipped_start_x,
  output lscr_pkg::coord_t      out_clipped_start_y,
  output lscr_pkg::coord_t      out_clipped_end_x,
  output lscr_pkg::coord_t      out_clipped_end_y
);
  import lscr_pkg::*;

  window_t win_r;
  seg_t    q_data;
  logic    q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= '0;
      win_r.bottom <= '0;
      win_r.right  <= COORD_MAX;
      win_r.top    <= COORD_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   win_r.left   <= cfg_wdata;
        REG_BOTTOM: win_r.bottom <= cfg_wdata;
        REG_RIGHT:  win_r.right  <= cfg_wdata;
        REG_TOP:    win_r.top    <= cfg_wdata;
        default:    win_r.left   <= win_r.left;
      endcase
    end
  end

  lscr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .win        (win_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  lscr_back #(.MAX_PASSES(MAX_PASSES)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .win                 (win_r),
    .q_valid             (q_valid),
    .q_data              (q_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_clipped_start_x (out_clipped_start_x),
    .out_clipped_start_y (out_clipped_start_y),
    .out_clipped_end_x   (out_clipped_end_x),
    .out_clipped_end_y   (out_clipped_end_y)
  );

  `LSCR_ASSERT(a_reject_zero, (out_valid && !out_accepted) |->
      (out_clipped_start_x == '0) && (out_clipped_start_y == '0) &&
      (out_clipped_end_x == '0) && (out_clipped_end_y == '0),
      "rejected segment carries nonzero coordinates")
  `LSCR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid right after reset")

endmodule
`default_nettype wire

/* hw/rtl/lscr_front.sv */
// Front end: takes segments, computes endpoint outcodes, holds a two-entry queue.
`default_nettype none
`include "assert_macros.svh"
module lscr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lscr_pkg::coord_t in_start_x,
  input  wire lscr_pkg::coord_t in_start_y,
  input  wire lscr_pkg::coord_t in_end_x,
  input  wire lscr_pkg::coord_t in_end_y,
  input  wire lscr_pkg::window_t win,
  output logic                 q_valid,
  output lscr_pkg::seg_t       q_data,
  input  wire logic            q_pop
);
  import lscr_pkg::*;

  seg_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  seg_t       seg_in;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  always_comb begin
    seg_in.ax = in_start_x;
    seg_in.ay = in_start_y;
    seg_in.bx = in_end_x;
    seg_in.by = in_end_y;
    seg_in.ca = region_of(in_start_x, in_start_y, win);
    seg_in.cb = region_of(in_end_x, in_end_y, win);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= seg_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `LSCR_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")
  `LSCR_ASSERT(a_cnt_bound, cnt_r != 2'd3, "queue count overflow")
  `LSCR_ASSERT(a_cnt_step, (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1,
               "queue count lost a push")

endmodule
`default_nettype wire

/* hw/rtl/lscr_div.sv */
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
`include "assert_macros.svh"
module lscr_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [49:0] dividend,
  input  wire logic signed [24:0] divisor,
  output logic                    done,
  output logic signed [49:0]      quotient
);
  localparam int DW = 49;

  logic [DW-1:0] quo_r;
  logic [24:0]   rem_r;
  logic [24:0]   dvs_r;
  logic [5:0]    cnt_r;
  logic          neg_r, zero_r, done_r;
  logic [25:0]   rem_sh;
  logic          fits;
  logic [49:0]   dend_abs;
  logic [24:0]   dvs_abs;

  assign dend_abs = dividend[49] ? -dividend : dividend;
  assign dvs_abs  = divisor[24] ? -divisor : divisor;
  assign rem_sh   = {rem_r, quo_r[DW-1]};
  assign fits     = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dend_abs[DW-1:0];
      dvs_r  <= dvs_abs;
      rem_r  <= '0;
      neg_r  <= dividend[49] ^ divisor[24];
      zero_r <= (divisor == '0);
    end else if (cnt_r != 6'd0) begin
      rem_r <= fits ? 25'(rem_sh - {1'b0, dvs_r}) : rem_sh[24:0];
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 6'd1);
      if (start) cnt_r <= 6'(DW);
      else if (cnt_r != 6'd0) cnt_r <= cnt_r - 6'd1;
    end
  end

  assign done = done_r;
  always_comb begin
    if (zero_r) quotient = '0;
    else if (neg_r) quotient = -$signed({1'b0, quo_r});
    else quotient = $signed({1'b0, quo_r});
  end

  `LSCR_ASSERT(a_cnt_range, cnt_r <= 6'(DW), "divider count out of range")
  `LSCR_ASSERT(a_no_restart, (cnt_r > 6'd1) |-> !start, "divider restarted while busy")

endmodule
`default_nettype wire

/* hw/rtl/lscr_back.sv */
// Back end: clip sequencer with multiplier, shared divider and output register.
`default_nettype none
`include "assert_macros.svh"
module lscr_back #(
  parameter int MAX_PASSES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lscr_pkg::window_t win,
  input  wire logic              q_valid,
  input  wire lscr_pkg::seg_t    q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_accepted,
  output lscr_pkg::coord_t       out_clipped_start_x,
  output lscr_pkg::coord_t       out_clipped_start_y,
  output lscr_pkg::coord_t       out_clipped_end_x,
  output lscr_pkg::coord_t       out_clipped_end_y
);
  import lscr_pkg::*;

  localparam int PW = $clog2(MAX_PASSES + 1);
  localparam logic [PW-1:0] PASS_LIM = PW'(MAX_PASSES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TEST  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DIVGO = 8'b0000_1000,
    S_DIVW  = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_CODE  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  coord_t ax_r, ay_r, bx_r, by_r;
  code_t  ca_r, cb_r;
  logic [PW-1:0] pass_r;
  logic signed [24:0] span_r, reach_r, run_r;
  coord_t base_r, edge_r;
  logic   horiz_r, mv_b_r, ok_r;
  logic signed [49:0] prod_r;

  logic signed [49:0] quo;
  logic               div_done;
  logic signed [50:0] sum;
  coord_t             res, nx, ny;
  code_t              cout;
  logic               fin_ok, fin_rej;
  logic               out_free;

  lscr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIVGO),
    .dividend (prod_r),
    .divisor  (run_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign cout     = (cb_r > ca_r) ? cb_r : ca_r;
  assign fin_ok   = ((ca_r | cb_r) == '0);
  assign fin_rej  = ((ca_r & cb_r) != '0) || (pass_r == PASS_LIM);
  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // Intersection coordinate, saturated to the 24-bit range.
  assign sum = 51'(base_r) + 51'(quo);
  always_comb begin
    if (sum > 51'(COORD_MAX)) res = COORD_MAX;
    else if (sum < 51'(COORD_MIN)) res = COORD_MIN;
    else res = sum[23:0];
    nx = horiz_r ? res : edge_r;
    ny = horiz_r ? edge_r : res;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_TEST;
      S_TEST:  if (fin_ok || fin_rej) state_nxt = S_DONE;
               else state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW:  if (div_done) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_CODE;
      S_CODE:  state_nxt = S_TEST;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ax_r   <= q_data.ax;
        ay_r   <= q_data.ay;
        bx_r   <= q_data.bx;
        by_r   <= q_data.by;
        ca_r   <= q_data.ca;
        cb_r   <= q_data.cb;
        pass_r <= '0;
      end
      S_TEST: begin
        ok_r   <= fin_ok;
        mv_b_r <= (cb_r > ca_r);
        if ((cout & CODE_TOP) != '0) begin
          span_r <= 25'(bx_r) - 25'(ax_r);
          reach_r <= 25'(win.top) - 25'(ay_r);
          run_r <= 25'(by_r) - 25'(ay_r);
          base_r <= ax_r; edge_r <= win.top; horiz_r <= 1'b1;
        end else if ((cout & CODE_BOTTOM) != '0) begin
          span_r <= 25'(bx_r) - 25'(ax_r);
          reach_r <= 25'(win.bottom) - 25'(ay_r);
          run_r <= 25'(by_r) - 25'(ay_r);
          base_r <= ax_r; edge_r <= win.bottom; horiz_r <= 1'b1;
        end else if ((cout & CODE_RIGHT) != '0) begin
          span_r <= 25'(by_r) - 25'(ay_r);
          reach_r <= 25'(win.right) - 25'(ax_r);
          run_r <= 25'(bx_r) - 25'(ax_r);
          base_r <= ay_r; edge_r <= win.right; horiz_r <= 1'b0;
        end else begin
          span_r <= 25'(by_r) - 25'(ay_r);
          reach_r <= 25'(win.left) - 25'(ax_r);
          run_r <= 25'(bx_r) - 25'(ax_r);
          base_r <= ay_r; edge_r <= win.left; horiz_r <= 1'b0;
        end
      end
      S_MUL: prod_r <= span_r * reach_r;
      S_FIN: begin
        if (mv_b_r) begin
          bx_r <= nx; by_r <= ny;
        end else begin
          ax_r <= nx; ay_r <= ny;
        end
      end
      S_CODE: begin
        // Codes are exact if the user keeps the window static during an item; not enforced.
        ca_r   <= region_of(ax_r, ay_r, win);
        cb_r   <= region_of(bx_r, by_r, win);
        pass_r <= pass_r + PW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_accepted        <= ok_r;
          out_clipped_start_x <= ok_r ? ax_r : '0;
          out_clipped_start_y <= ok_r ? ay_r : '0;
          out_clipped_end_x   <= ok_r ? bx_r : '0;
          out_clipped_end_y   <= ok_r ? by_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  `LSCR_ASSERT(a_pass_bound, pass_r <= PASS_LIM, "clip pass count past limit")
  `LSCR_ASSERT(a_done_in_wait, div_done |-> state_r == S_DIVW,
               "divider finished outside wait state")

endmodule
`default_nettype wire
